// ===== design/actr_pkg.sv =====
`timescale 1ns / 1ps
package actr_pkg;
  localparam int unsigned KeyW = 64;
  localparam int unsigned CfgIdxW = 1;

  typedef enum logic [0:0] {
    REG_KEY_LOW  = 1'b0,
    REG_KEY_HIGH = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_ENC,
    ST_OUT
  } state_e;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    logic [7:0] x;
    r = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r = r ^ x;
      x = xtime(x);
    end
    gf_mul = r;
  endfunction

  // aes s-box, computed as logic from the inverse x^254 and the affine map; 0 maps to 0 via x^254
  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] inv;
    logic [7:0] base;
    inv = 8'h01;
    base = x;
    for (int i = 0; i < 8; i++) begin
      if (i != 0) inv = gf_mul(inv, base);
      base = gf_mul(base, base);
    end
    sbox = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
         ^ {inv[3:0], inv[7:4]} ^ 8'h63;
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  // state is 128 bits, byte 0 in [127:120], column-major
  function automatic logic [127:0] round_fn(input logic [127:0] s, input logic [127:0] rk,
                                            input logic last);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    logic [127:0] o;
    for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[4*c+r] = sbox(b[4*((c+r)%4)+r]);
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        al = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) o[127-8*i -: 8] = t[i];
    round_fn = o ^ rk;
  endfunction
endpackage

// ===== design/actr_byte_if.sv =====
`timescale 1ns / 1ps
interface actr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/aes128_ctr_stream_cipher_top.sv =====
`timescale 1ns / 1ps
// byte-stream aes-128 counter-mode cipher
// in_if carries one input word per byte, out_if one output word per byte
// key: cfg_we_i with cfg_idx_i 0 (bytes 0..7) or 1 (bytes 8..15), any write
// re-expands the round keys (block not ready meanwhile),
// clears the counter and empties the keystream
// an input word is taken when the block is idle; for a byte of the current
// keystream block the accepting edge moves the block to ST_OUT, which
// registers the output word once the output register is free and returns
// to idle, so no new byte is taken before the last one's output is registered
// when the keystream is used up the counter is incremented and encrypted by
// a single round unit, one aes round per cycle over the 11 round keys read
// from the key memory in ST_ENC, before ST_OUT registers the output word
// a stalled receiver holds the output word; one more word is taken and waits
// for the output register, after that in_if stays not ready
// reset clears the counter and the keystream, the round keys are
// undefined until a key is written
module aes128_ctr_stream_cipher_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [actr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [actr_pkg::KeyW-1:0]  cfg_data_i,
  actr_byte_if.sink                  in_if,
  actr_byte_if.source                out_if
);
  import actr_pkg::*;

  state_e state_q, state_d;
  logic [63:0]  key_lo_q, key_hi_q;
  logic [63:0]  key_lo_d, key_hi_d;
  logic [127:0] ctr_q, ctr_d;
  logic [127:0] ks_q, ks_d;
  logic [4:0]   off_q, off_d;
  logic [3:0]   cnt_q, cnt_d;
  logic [127:0] wk_q, wk_d;
  logic [7:0]   rcon_q, rcon_d;
  logic [7:0]   din_q, din_d;
  logic [7:0]   dout_q, dout_d;
  logic         ovld_q, ovld_d;

  logic         mem_we;
  logic [3:0]   mem_waddr, mem_raddr;
  logic [127:0] mem_wdata, rk;
  logic         ru_load, ru_step, ru_last;
  logic [127:0] ru_state;
  logic [127:0] key_full, next_wk;
  logic [31:0]  tw;

  // key as it stands after this cycle's register write
  assign key_lo_d = (cfg_we_i && cfg_idx_i == REG_KEY_LOW) ? cfg_data_i : key_lo_q;
  assign key_hi_d = (cfg_we_i && cfg_idx_i == REG_KEY_HIGH) ? cfg_data_i : key_hi_q;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      key_full[127-8*k -: 8]     = key_lo_d[8*k +: 8];
      key_full[127-8*(k+8) -: 8] = key_hi_d[8*k +: 8];
    end
  end

  assign tw = sub_word({wk_q[23:0], wk_q[31:24]}) ^ {rcon_q, 24'h0};
  always_comb begin
    next_wk[127:96] = wk_q[127:96] ^ tw;
    next_wk[95:64]  = wk_q[95:64] ^ next_wk[127:96];
    next_wk[63:32]  = wk_q[63:32] ^ next_wk[95:64];
    next_wk[31:0]   = wk_q[31:0] ^ next_wk[63:32];
  end

  actr_key_mem u_mem (
    .clk_i, .we_i(mem_we), .waddr_i(mem_waddr), .wdata_i(mem_wdata),
    .raddr_i(mem_raddr), .rdata_o(rk)
  );

  actr_round_unit u_round (
    .clk_i, .load_i(ru_load), .step_i(ru_step), .last_i(ru_last),
    .blk_i(ctr_q), .rk_i(rk), .state_o(ru_state)
  );

  assign in_if.ready  = (state_q == ST_IDLE);
  assign out_if.valid = ovld_q;
  assign out_if.data  = dout_q;

  always_comb begin
    state_d = state_q; ctr_d = ctr_q; ks_d = ks_q; off_d = off_q; cnt_d = cnt_q;
    wk_d = wk_q; rcon_d = rcon_q; din_d = din_q; dout_d = dout_q; ovld_d = ovld_q;
    mem_we = 1'b0; mem_waddr = cnt_q; mem_wdata = wk_q; mem_raddr = 4'd0;
    ru_load = 1'b0; ru_step = 1'b0; ru_last = 1'b0;
    if (out_if.valid && out_if.ready) ovld_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_if.valid && in_if.ready) begin
          din_d = in_if.data;
          if (off_q[4]) begin
            ctr_d = ctr_q + 128'd1;
            cnt_d = 4'd0;
            state_d = ST_ENC;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_EXPAND: begin
        mem_we = 1'b1;
        wk_d = next_wk;
        rcon_d = xtime(rcon_q);
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd10) state_d = ST_IDLE;
      end
      ST_ENC: begin
        // cnt 0 reads rk0; cnt n>=1 applies round n-1 data
        ru_load = (cnt_q == 4'd1);
        ru_step = (cnt_q > 4'd1);
        ru_last = (cnt_q == 4'd11);
        if (cnt_q != 4'd11) mem_raddr = cnt_q;
        else mem_raddr = 4'd10;
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd11) begin
          state_d = ST_OUT;
          off_d = 5'd0;
        end
      end
      ST_OUT: begin
        // wait here while the previous output word is still held
        if (!ovld_q || out_if.ready) begin
          dout_d = din_q ^ ks_q[127-8*off_q[3:0] -: 8];
          ovld_d = 1'b1;
          off_d = off_q + 5'd1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (ru_last) ks_d = round_fn(ru_state, rk, 1'b1);
    if (cfg_we_i) begin
      ctr_d = '0; ks_d = '0; off_d = 5'd16; cnt_d = 4'd0;
      wk_d = key_full; rcon_d = 8'h01; state_d = ST_EXPAND;
    end
  end

  // round unit load uses rk read with raddr 0 in the prior cycle
  // cnt0 reads rk0, cnt1 loads with rk0 and reads rk1, ... cnt10 step round 9
  // with rk9 and reads rk10, cnt11 final round with rk10 into keystream

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; ctr_q <= '0; ks_q <= '0; off_q <= 5'd16; cnt_q <= 4'd0;
      ovld_q <= 1'b0; key_lo_q <= '0; key_hi_q <= '0; rcon_q <= 8'h01;
    end else begin
      state_q <= state_d; ctr_q <= ctr_d; ks_q <= ks_d; off_q <= off_d; cnt_q <= cnt_d;
      ovld_q <= ovld_d; rcon_q <= rcon_d;
      key_lo_q <= key_lo_d; key_hi_q <= key_hi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wk_q <= wk_d;
    din_q <= din_d; dout_q <= dout_d;
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid) else $error("output word dropped");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> !in_if.ready) else $error("ready while busy");
  a_off_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    off_q <= 5'd16) else $error("keystream offset out of range");
endmodule

// ===== design/actr_key_mem.sv =====
`timescale 1ns / 1ps
module actr_key_mem (
  input  logic        clk_i,
  input  logic        we_i,
  input  logic [3:0]  waddr_i,
  input  logic [127:0] wdata_i,
  input  logic [3:0]  raddr_i,
  output logic [127:0] rdata_o
);
  logic [127:0] mem [11];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== design/actr_round_unit.sv =====
`timescale 1ns / 1ps
module actr_round_unit (
  input  logic         clk_i,
  input  logic         load_i,
  input  logic         step_i,
  input  logic         last_i,
  input  logic [127:0] blk_i,
  input  logic [127:0] rk_i,
  output logic [127:0] state_o
);
  import actr_pkg::*;
  logic [127:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    if (load_i) state_d = blk_i ^ rk_i;
    else if (step_i) state_d = round_fn(state_q, rk_i, last_i);
  end

  always_ff @(posedge clk_i) begin
    state_q <= state_d;
  end

  assign state_o = state_q;
endmodule
